FILE: design/stdet_pkg.sv
// ============================================================================
// stdet_pkg: shared types and constants of the stuck thermostat detector
// Holds the verdict codes, register indexes, sentinel readings, reset
// values and the structs passed between the detector's modules.
// ============================================================================
package stdet_pkg;

    // Width of the internal time base; time stamps are reduced to this width.
    localparam int TIME_BITS = 48;

    localparam int NOW_W   = 48;
    localparam int TEMP_W  = 32;
    localparam int WATTS_W = 16;
    localparam int VERD_W  = 2;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [VERD_W-1:0]    verdict_t;

    // Verdict codes.
    localparam verdict_t V_UNKNOWN = 2'd0;
    localparam verdict_t V_OK      = 2'd1;
    localparam verdict_t V_SUSPECT = 2'd2;
    localparam verdict_t V_FAULT   = 2'd3;

    // Register indexes (word address).
    localparam logic [2:0] REG_MIN_DRAW_TIME  = 3'd0;
    localparam logic [2:0] REG_DRAW_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_OVER_TARGET    = 3'd2;
    localparam logic [2:0] REG_MAX_GAP        = 3'd3;
    localparam logic [2:0] REG_PROBE_MIN      = 3'd4;
    localparam logic [2:0] REG_PROBE_MAX      = 3'd5;
    localparam logic [2:0] REG_SETPOINT_MIN   = 3'd6;
    localparam logic [2:0] REG_SETPOINT_MAX   = 3'd7;

    // Reset values of the registers.
    localparam logic [31:0]        RST_MIN_DRAW_TIME  = 32'd2700000;
    localparam logic [15:0]        RST_DRAW_THRESHOLD = 16'd50;
    localparam logic [15:0]        RST_OVER_TARGET    = 16'd1000;
    localparam logic [31:0]        RST_MAX_GAP        = 32'd600000;
    localparam logic signed [31:0] RST_PROBE_MIN      = 32'sd0;
    localparam logic signed [31:0] RST_PROBE_MAX      = 32'sd40000;
    localparam logic signed [31:0] RST_SETPOINT_MIN   = 32'sd18000;
    localparam logic signed [31:0] RST_SETPOINT_MAX   = 32'sd32000;

    // Probe readings that the sensor reports when it is not giving real data.
    localparam logic signed [31:0] SENTINEL_POWER_ON  = 32'sd85000;
    localparam logic signed [31:0] SENTINEL_UNPLUGGED = -32'sd127000;

    typedef struct packed {
        logic [31:0]        min_draw_time_ms;
        logic [15:0]        draw_level_dw;
        logic [15:0]        hot_margin_mc;
        logic [31:0]        gap_limit_ms;
        logic signed [31:0] probe_min_mc;
        logic signed [31:0] probe_max_mc;
        logic signed [31:0] setpoint_min_mc;
        logic signed [31:0] setpoint_max_mc;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        time_t              now_ms;
        logic               heat_cmd;
        logic [15:0]        power_dw;
        logic signed [31:0] tank_temp_mc;
        logic signed [31:0] setpoint_mc;
    } sample_t;

endpackage

FILE: design/stdet_cfg_regs.sv
// ============================================================================
// stdet_cfg_regs: configuration register file
// APB-style slave holding the eight detector thresholds. Writes land at the
// access phase; reads return the stored value.
// ============================================================================
module stdet_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [stdet_pkg::APB_AW-1:0] paddr,
    input  logic [stdet_pkg::APB_DW-1:0] pwdata,
    output logic [stdet_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output stdet_pkg::cfg_t            cfg
);
    import stdet_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_draw_time_ms <= RST_MIN_DRAW_TIME;
            cfg_reg.draw_level_dw    <= RST_DRAW_THRESHOLD;
            cfg_reg.hot_margin_mc    <= RST_OVER_TARGET;
            cfg_reg.gap_limit_ms     <= RST_MAX_GAP;
            cfg_reg.probe_min_mc     <= RST_PROBE_MIN;
            cfg_reg.probe_max_mc     <= RST_PROBE_MAX;
            cfg_reg.setpoint_min_mc  <= RST_SETPOINT_MIN;
            cfg_reg.setpoint_max_mc  <= RST_SETPOINT_MAX;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_DRAW_TIME:  cfg_reg.min_draw_time_ms <= pwdata;
                REG_DRAW_THRESHOLD: cfg_reg.draw_level_dw    <= pwdata[15:0];
                REG_OVER_TARGET:    cfg_reg.hot_margin_mc    <= pwdata[15:0];
                REG_MAX_GAP:        cfg_reg.gap_limit_ms     <= pwdata;
                REG_PROBE_MIN:      cfg_reg.probe_min_mc     <= pwdata;
                REG_PROBE_MAX:      cfg_reg.probe_max_mc     <= pwdata;
                REG_SETPOINT_MIN:   cfg_reg.setpoint_min_mc  <= pwdata;
                REG_SETPOINT_MAX:   cfg_reg.setpoint_max_mc  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_DRAW_TIME:  prdata = cfg_reg.min_draw_time_ms;
            REG_DRAW_THRESHOLD: prdata = {16'd0, cfg_reg.draw_level_dw};
            REG_OVER_TARGET:    prdata = {16'd0, cfg_reg.hot_margin_mc};
            REG_MAX_GAP:        prdata = cfg_reg.gap_limit_ms;
            REG_PROBE_MIN:      prdata = cfg_reg.probe_min_mc;
            REG_PROBE_MAX:      prdata = cfg_reg.probe_max_mc;
            REG_SETPOINT_MIN:   prdata = cfg_reg.setpoint_min_mc;
            REG_SETPOINT_MAX:   prdata = cfg_reg.setpoint_max_mc;
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: design/stdet_judge.sv
// ============================================================================
// stdet_judge: verdict logic and detector state
// Judges the sample held in the input stage and updates the run state at
// the edge where that sample moves on to the result stage.
// ============================================================================
module stdet_judge (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  stdet_pkg::sample_t smp,
    input  stdet_pkg::cfg_t    cfg,
    output stdet_pkg::verdict_t verdict
);
    import stdet_pkg::*;

    verdict_t           cur_verdict_reg, cur_verdict_next;
    logic               in_run_reg, in_run_next;
    time_t              run_start_time_reg, run_start_time_next;
    logic signed [31:0] run_start_temp_reg, run_start_temp_next;
    time_t              last_time_reg, last_time_next;
    logic               have_prev_reg, have_prev_next;

    logic [TIME_BITS:0]  gap_diff;
    logic [TIME_BITS:0]  run_diff;
    logic                cont;
    logic                setpoint_bad;
    logic                probe_bad;
    logic                drawing;
    logic signed [33:0]  hot_limit;
    logic                too_hot;
    logic                climbing;
    time_t               elapsed;
    verdict_t            judged;

    // Gap to the previous sample; the top bit flags time running backwards.
    assign gap_diff = {1'b0, smp.now_ms} - {1'b0, last_time_reg};
    assign cont = !have_prev_reg ||
                  (!gap_diff[TIME_BITS] &&
                   (gap_diff[TIME_BITS-1:0] <= time_t'(cfg.gap_limit_ms)));

    assign setpoint_bad = (smp.setpoint_mc < cfg.setpoint_min_mc) ||
                          (smp.setpoint_mc > cfg.setpoint_max_mc);
    assign probe_bad = (smp.tank_temp_mc == SENTINEL_POWER_ON) ||
                       (smp.tank_temp_mc == SENTINEL_UNPLUGGED) ||
                       (smp.tank_temp_mc < cfg.probe_min_mc) ||
                       (smp.tank_temp_mc > cfg.probe_max_mc);
    assign drawing = smp.heat_cmd && (smp.power_dw > cfg.draw_level_dw);

    // The over-target limit is formed two bits wider so it cannot wrap.
    assign hot_limit = 34'(smp.setpoint_mc) + $signed({18'd0, cfg.hot_margin_mc});
    assign too_hot   = 34'(smp.tank_temp_mc) > hot_limit;
    assign climbing  = smp.tank_temp_mc > run_start_temp_reg;

    assign run_diff = {1'b0, smp.now_ms} - {1'b0, run_start_time_reg};
    assign elapsed  = run_diff[TIME_BITS] ? '0 : run_diff[TIME_BITS-1:0];

    always_comb begin
        cur_verdict_next    = cur_verdict_reg;
        in_run_next         = in_run_reg;
        run_start_time_next = run_start_time_reg;
        run_start_temp_next = run_start_temp_reg;
        last_time_next      = last_time_reg;
        have_prev_next      = have_prev_reg;
        judged              = V_UNKNOWN;

        priority if (smp.mode) begin
            cur_verdict_next    = V_UNKNOWN;
            in_run_next         = 1'b0;
            run_start_time_next = '0;
            run_start_temp_next = '0;
            last_time_next      = '0;
            have_prev_next      = 1'b0;
            judged              = V_UNKNOWN;
        end else if (cur_verdict_reg == V_FAULT) begin
            // A latched fault ignores the sample completely.
            judged = V_FAULT;
        end else begin
            last_time_next = smp.now_ms;
            have_prev_next = 1'b1;
            priority if (!cont) begin
                in_run_next = 1'b0;
                judged      = V_UNKNOWN;
            end else if (setpoint_bad || probe_bad) begin
                in_run_next = 1'b0;
                judged      = V_SUSPECT;
            end else if (!drawing) begin
                in_run_next = 1'b0;
                judged      = V_OK;
            end else if (!in_run_reg) begin
                in_run_next         = 1'b1;
                run_start_time_next = smp.now_ms;
                run_start_temp_next = smp.tank_temp_mc;
                judged              = V_OK;
            end else begin
                if (run_diff[TIME_BITS]) begin
                    run_start_time_next = smp.now_ms;
                end
                if (elapsed < time_t'(cfg.min_draw_time_ms)) begin
                    judged = (too_hot && climbing) ? V_SUSPECT : V_OK;
                end else begin
                    judged = (too_hot && climbing) ? V_FAULT : V_SUSPECT;
                end
            end
            cur_verdict_next = judged;
        end
    end

    assign verdict = judged;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_verdict_reg    <= V_UNKNOWN;
            in_run_reg         <= 1'b0;
            run_start_time_reg <= '0;
            run_start_temp_reg <= '0;
            last_time_reg      <= '0;
            have_prev_reg      <= 1'b0;
        end else if (advance) begin
            cur_verdict_reg    <= cur_verdict_next;
            in_run_reg         <= in_run_next;
            run_start_time_reg <= run_start_time_next;
            run_start_temp_reg <= run_start_temp_next;
            last_time_reg      <= last_time_next;
            have_prev_reg      <= have_prev_next;
        end
    end

endmodule

FILE: design/stuck_thermostat_detector_unit.sv
// ============================================================================
// stuck_thermostat_detector_unit: heater sample verdict engine
// Judges one heater sample per word and answers unknown, ok, suspect or
// fault, with thresholds set through an APB-style register port.
// ============================================================================
// Usage: samples arrive on the s_ channel (valid/ready). Each word carries
// the mode bit (restart or evaluate), time stamp, relay command, power,
// water temperature and setpoint. Every accepted word produces exactly one
// verdict word on the m_ channel, in order.
// The word is captured in an input register at the edge that accepts it,
// then judged by a single level of compares and subtracts against the
// detector state and loaded into the result register, where m_valid rises,
// once that register is free. The state updates at that same edge, so the
// next word sees it. Throughput is one word per cycle while the receiver
// keeps m_ready high; the bound is the 48-bit time subtract and compare
// between the input and result registers.
// Reset (aresetn low, synchronous) empties both stages, loads the register
// defaults and clears the detector state, including a latched fault.
// When the receiver holds m_ready low, the result word stays put, one more
// word may wait in the input register, and s_ready then falls until the
// result is taken. Registers should be written only while the unit is idle.
// ============================================================================
module stuck_thermostat_detector_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Sample channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [stdet_pkg::NOW_W-1:0]       s_now_ms,
    input  logic                              s_heat_cmd,
    input  logic [stdet_pkg::WATTS_W-1:0]     s_power_dw,
    input  logic signed [stdet_pkg::TEMP_W-1:0] s_tank_temp_mc,
    input  logic signed [stdet_pkg::TEMP_W-1:0] s_setpoint_mc,
    // Verdict channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [stdet_pkg::VERD_W-1:0]      m_verdict,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stdet_pkg::APB_AW-1:0]      paddr,
    input  logic [stdet_pkg::APB_DW-1:0]      pwdata,
    output logic [stdet_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import stdet_pkg::*;

    cfg_t     cfg;
    sample_t  in_word_reg;
    logic     in_valid_reg;
    logic     out_valid_reg;
    verdict_t out_verdict_reg;
    verdict_t verdict;
    logic     advance;
    logic     out_free;

    stdet_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The result register frees up when it is empty or being taken this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // The held word is judged and moves on whenever the result slot is free.
    assign advance  = in_valid_reg && out_free;
    // The input register takes a new word when it is empty or moving on.
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg.mode         <= s_mode;
            in_word_reg.now_ms       <= time_t'(s_now_ms);
            in_word_reg.heat_cmd     <= s_heat_cmd;
            in_word_reg.power_dw     <= s_power_dw;
            in_word_reg.tank_temp_mc <= s_tank_temp_mc;
            in_word_reg.setpoint_mc  <= s_setpoint_mc;
        end
    end

    stdet_judge u_judge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .smp     (in_word_reg),
        .cfg     (cfg),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_verdict_reg <= verdict;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_verdict = out_verdict_reg;

endmodule

FILE: tb/stuck_thermostat_detector_unit_tb.sv
// ============================================================================
// stuck_thermostat_detector_unit_tb: self-checking bench for the verdict unit
// Sends heater samples through the s_ channel under varied register settings
// and idle patterns. Each verdict word on the m_ channel is checked in order
// against a behavioral predictor of the detector kept inside the bench.
// ============================================================================
`timescale 1ns / 100ps

module stuck_thermostat_detector_unit_tb;
    import stdet_pkg::*;

    // Generous bound on the whole run, in clock cycles. The slowest correct
    // run (both sides idling heavily, every register rewritten per setting)
    // stays well below this.
    localparam int CYCLE_LIMIT = 200000;
    localparam int WORDS_PER_SETTING = 160;
    localparam int SETTING_COUNT = 8;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode;
    logic [NOW_W-1:0] s_now_ms;
    logic s_heat_cmd;
    logic [WATTS_W-1:0] s_power_dw;
    logic signed [TEMP_W-1:0] s_tank_temp_mc;
    logic signed [TEMP_W-1:0] s_setpoint_mc;

    logic m_valid;
    logic m_ready = 1'b0;
    logic [VERD_W-1:0] m_verdict;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // The sample word currently presented on the s_ channel.
    sample_t drv_word = '0;

    assign s_mode         = drv_word.mode;
    assign s_now_ms       = drv_word.now_ms;
    assign s_heat_cmd     = drv_word.heat_cmd;
    assign s_power_dw     = drv_word.power_dw;
    assign s_tank_temp_mc = drv_word.tank_temp_mc;
    assign s_setpoint_mc  = drv_word.setpoint_mc;

    stuck_thermostat_detector_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_now_ms       (s_now_ms),
        .s_heat_cmd     (s_heat_cmd),
        .s_power_dw     (s_power_dw),
        .s_tank_temp_mc (s_tank_temp_mc),
        .s_setpoint_mc  (s_setpoint_mc),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    sample_t  pending_samples[$];    // words still to be sent
    verdict_t expected_verdicts[$];  // predicted verdicts, oldest first

    int items_queued = 0;
    int words_checked = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int settings_done = 0;
    int verdict_seen[4] = '{0, 0, 0, 0};

    // Idle pattern of the current phase, in percent of cycles.
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;

    // Set when the s_ word was taken at the last rising edge.
    logic s_took = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor: the register file as last written, and the detector's state.
    // ------------------------------------------------------------------------
    cfg_t model_cfg = '{
        min_draw_time_ms: RST_MIN_DRAW_TIME,
        draw_level_dw:    RST_DRAW_THRESHOLD,
        hot_margin_mc:    RST_OVER_TARGET,
        gap_limit_ms:     RST_MAX_GAP,
        probe_min_mc:     RST_PROBE_MIN,
        probe_max_mc:     RST_PROBE_MAX,
        setpoint_min_mc:  RST_SETPOINT_MIN,
        setpoint_max_mc:  RST_SETPOINT_MAX
    };

    verdict_t det_verdict   = V_UNKNOWN;
    logic     det_in_run    = 1'b0;
    time_t    det_run_t0    = '0;
    longint   det_run_temp0 = 0;
    time_t    det_last_t    = '0;
    logic     det_have_prev = 1'b0;

    // Works out the verdict for one accepted word and advances the state.
    function automatic verdict_t predict_verdict(input sample_t smp);
        longint wat;
        longint tgt;
        logic contiguous;
        logic hot_rising;
        time_t elapsed;
        wat = smp.tank_temp_mc;
        tgt = smp.setpoint_mc;
        if (smp.mode) begin
            // A restart clears the whole detector, latch included.
            det_verdict   = V_UNKNOWN;
            det_in_run    = 1'b0;
            det_run_t0    = '0;
            det_run_temp0 = 0;
            det_last_t    = '0;
            det_have_prev = 1'b0;
            return V_UNKNOWN;
        end
        // A latched fault ignores the sample entirely, time stamp included.
        if (det_verdict == V_FAULT) return V_FAULT;

        contiguous = !det_have_prev ||
                     (smp.now_ms >= det_last_t &&
                      smp.now_ms - det_last_t <= time_t'(model_cfg.gap_limit_ms));
        det_last_t    = smp.now_ms;
        det_have_prev = 1'b1;

        if (!contiguous) begin
            det_in_run  = 1'b0;
            det_verdict = V_UNKNOWN;
        end else if (tgt < longint'(model_cfg.setpoint_min_mc) ||
                     tgt > longint'(model_cfg.setpoint_max_mc)) begin
            det_in_run  = 1'b0;
            det_verdict = V_SUSPECT;
        end else if (wat == longint'(SENTINEL_POWER_ON) ||
                     wat == longint'(SENTINEL_UNPLUGGED) ||
                     wat < longint'(model_cfg.probe_min_mc) ||
                     wat > longint'(model_cfg.probe_max_mc)) begin
            det_in_run  = 1'b0;
            det_verdict = V_SUSPECT;
        end else if (!(smp.heat_cmd && smp.power_dw > model_cfg.draw_level_dw)) begin
            det_in_run  = 1'b0;
            det_verdict = V_OK;
        end else if (!det_in_run) begin
            // First drawing sample opens the run.
            det_in_run    = 1'b1;
            det_run_t0    = smp.now_ms;
            det_run_temp0 = wat;
            det_verdict   = V_OK;
        end else begin
            // The over-target sum is taken in 64 bits so it cannot wrap.
            hot_rising = wat > tgt + longint'(model_cfg.hot_margin_mc) &&
                         wat > det_run_temp0;
            if (smp.now_ms < det_run_t0) det_run_t0 = smp.now_ms;
            elapsed = smp.now_ms - det_run_t0;
            if (elapsed < time_t'(model_cfg.min_draw_time_ms))
                det_verdict = hot_rising ? V_SUSPECT : V_OK;
            else
                det_verdict = hot_rising ? V_FAULT : V_SUSPECT;
        end
        return det_verdict;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_sample(input logic mode, input time_t now,
                                        input logic on, input logic [15:0] watts,
                                        input logic signed [31:0] water,
                                        input logic signed [31:0] target);
        sample_t smp;
        smp.mode         = mode;
        smp.now_ms       = now;
        smp.heat_cmd     = on;
        smp.power_dw     = watts;
        smp.tank_temp_mc = water;
        smp.setpoint_mc  = target;
        pending_samples.push_back(smp);
        items_queued++;
    endfunction

    function automatic time_t rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Uniform pick in [lo, hi]; the span may reach 2**32.
    function automatic longint rand_between(input longint lo, input longint hi);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return lo + longint'(r % 64'(hi - lo + 1));
    endfunction

    // Writes one register through the APB port and mirrors it in the
    // predictor. The write lands at the rising edge of the access cycle.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_DRAW_TIME:  model_cfg.min_draw_time_ms = value;
            REG_DRAW_THRESHOLD: model_cfg.draw_level_dw    = value[15:0];
            REG_OVER_TARGET:    model_cfg.hot_margin_mc    = value[15:0];
            REG_MAX_GAP:        model_cfg.gap_limit_ms     = value;
            REG_PROBE_MIN:      model_cfg.probe_min_mc     = value;
            REG_PROBE_MAX:      model_cfg.probe_max_mc     = value;
            REG_SETPOINT_MIN:   model_cfg.setpoint_min_mc  = value;
            REG_SETPOINT_MAX:   model_cfg.setpoint_max_mc  = value;
            default: ;
        endcase
    endtask

    // Every word yields one verdict, so the unit is idle once all queued
    // words have been answered; spare cycles at the end cover its two-stage pipe.
    task automatic wait_drained();
        while (words_checked < items_queued) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Random words shaped by the current registers. Most are well-formed
    // sample streams (time moving within the allowed gap, heater drawing,
    // water near or above target) so that draw runs grow long enough to
    // reach the suspect and fault verdicts. The rest are restarts, which
    // also release a latched fault, and fully random noise.
    task automatic queue_random(input int count);
        longint sp_lo;
        longint sp_hi;
        longint pr_lo;
        longint pr_hi;
        longint tgt;
        longint wat;
        logic [15:0] watts;
        time_t gen_now;
        int pick;
        sp_lo = model_cfg.setpoint_min_mc;
        sp_hi = model_cfg.setpoint_max_mc;
        pr_lo = model_cfg.probe_min_mc;
        pr_hi = model_cfg.probe_max_mc;
        gen_now = ($urandom_range(1) == 0) ? time_t'($urandom) : rand48();
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                push_sample(1'b1, rand48(), 1'($urandom), 16'($urandom),
                            $urandom, $urandom);
                gen_now = rand48();
            end else if (pick < 10) begin
                gen_now = rand48();
                push_sample(1'b0, gen_now, 1'($urandom), 16'($urandom),
                            $urandom, $urandom);
            end else begin
                // Time step: mostly inside the allowed gap, sometimes
                // exactly on it, past it, repeated or going backwards.
                pick = $urandom_range(99);
                if (pick < 4)
                    gen_now = gen_now - time_t'($urandom_range(1000, 1));
                else if (pick < 8)
                    gen_now = gen_now + time_t'(model_cfg.gap_limit_ms) + 48'd1 +
                              time_t'($urandom_range(1000));
                else if (pick < 15)
                    gen_now = gen_now + time_t'(model_cfg.gap_limit_ms);
                else if (pick >= 22)
                    gen_now = gen_now + time_t'($urandom_range(model_cfg.gap_limit_ms));

                // Setpoint: inside the band, on its edges, just outside it or fully random.
                pick = $urandom_range(99);
                if (sp_lo > sp_hi || pick < 4)
                    tgt = int'($urandom);
                else if (pick < 8)
                    tgt = (pick < 6) ? sp_lo - 1 : sp_hi + 1;
                else if (pick < 14)
                    tgt = sp_lo;
                else if (pick < 20)
                    tgt = sp_hi;
                else
                    tgt = rand_between(sp_lo, sp_hi);
                if (tgt < -64'sd2147483648 || tgt > 64'sd2147483647)
                    tgt = int'($urandom);

                // Probe: sentinels, implausible values, hot or ordinary.
                pick = $urandom_range(99);
                if (pick < 3)
                    wat = SENTINEL_POWER_ON;
                else if (pick < 6)
                    wat = SENTINEL_UNPLUGGED;
                else if (pick < 10 || pr_lo > pr_hi)
                    wat = int'($urandom);
                else if (pick < 55)
                    wat = tgt + longint'(model_cfg.hot_margin_mc) +
                          longint'($urandom_range(2000, 1));
                else
                    wat = rand_between(pr_lo, pr_hi);
                if (wat > 64'sd2147483647) wat = 64'sd2147483647;

                pick = $urandom_range(99);
                if (pick < 15 || model_cfg.draw_level_dw == 16'hFFFF)
                    watts = 16'($urandom_range(model_cfg.draw_level_dw));
                else
                    watts = 16'($urandom_range(16'hFFFF, model_cfg.draw_level_dw + 1));

                push_sample(1'b0, gen_now, 1'($urandom_range(9) != 0), watts,
                            32'(wat), 32'(tgt));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents one word at a time on the s_ channel and randomizes
    // m_ready. Everything changes on the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        sample_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            // A word stays up, unchanged, until it has been taken.
            if (!s_valid || s_took) begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_samples.pop_front();
                    drv_word <= nxt;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted sample word and checks every
    // accepted verdict word, sampling at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            // The verdict is popped before this edge's sample is predicted,
            // so an empty queue always means an unexpected word.
            if (m_valid && m_ready) begin
                words_checked++;
                if (expected_verdicts.size() == 0) begin
                    $error("verdict word %0d arrived with nothing expected (verdict %0d)",
                           words_checked, m_verdict);
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_verdict !== want) begin
                        $error("verdict: expected %0d, actual %0d (word %0d)",
                               want, m_verdict, words_checked);
                        fail_count++;
                    end else begin
                        verdict_seen[want]++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_verdicts.push_back(predict_verdict(drv_word));
            s_took <= s_valid && s_ready;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d verdict words seen",
                     cycle_count, words_checked, items_queued);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_t c;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset values of the registers: field
        // extremes, both modes, each verdict path and the latch.
        push_sample(1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(1'b0, 48'd0, 1'b0, 16'd0, 32'sd20000, 32'sd25000);
        // Power exactly on the threshold does not count as drawing.
        push_sample(1'b0, 48'd1000, 1'b1, 16'd50, 32'sd20000, 32'sd25000);
        push_sample(1'b0, 48'd2000, 1'b1, 16'd51, 32'sd20000, 32'sd25000);
        push_sample(1'b0, 48'd60000, 1'b1, 16'hFFFF, 32'sd27000, 32'sd25000);
        push_sample(1'b0, 48'd62000, 1'b1, 16'd51, 32'sd26000, 32'sd25000);
        // Steps of exactly the largest allowed gap keep the run alive.
        push_sample(1'b0, 48'd662000, 1'b1, 16'd300, 32'sd27000, 32'sd25000);
        push_sample(1'b0, 48'd1262000, 1'b1, 16'd300, 32'sd27000, 32'sd25000);
        push_sample(1'b0, 48'd1862000, 1'b1, 16'd300, 32'sd27000, 32'sd25000);
        push_sample(1'b0, 48'd2462000, 1'b1, 16'd300, 32'sd27000, 32'sd25000);
        // Run length exactly on the limit, water not too hot, then too hot.
        push_sample(1'b0, 48'd2702000, 1'b1, 16'd300, 32'sd26000, 32'sd25000);
        push_sample(1'b0, 48'd2702001, 1'b1, 16'd300, 32'sd40000, 32'sd25000);
        // Latched fault ignores even a backwards time stamp.
        push_sample(1'b0, 48'd0, 1'b1, 16'd300, 32'sd20000, 32'sd25000);
        push_sample(1'b1, 48'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
        // Probe sentinels and readings just outside the plausible band.
        push_sample(1'b0, 48'd0, 1'b1, 16'd100, 32'sd85000, 32'sd25000);
        push_sample(1'b0, 48'd10, 1'b1, 16'd100, -32'sd127000, 32'sd25000);
        push_sample(1'b0, 48'd20, 1'b1, 16'd100, 32'sd40001, 32'sd25000);
        push_sample(1'b0, 48'd30, 1'b1, 16'd100, -32'sd1, 32'sd25000);
        // Setpoint just below and above its band, then at the top of the 32-bit range.
        push_sample(1'b0, 48'd40, 1'b1, 16'd100, 32'sd20000, 32'sd17999);
        push_sample(1'b0, 48'd50, 1'b1, 16'd100, 32'sd20000, 32'sd32001);
        push_sample(1'b0, 48'd60, 1'b1, 16'd100, 32'sh8000_0000, 32'sh7FFF_FFFF);
        // One past the allowed gap, time going backwards, a huge jump.
        push_sample(1'b0, 48'd600061, 1'b1, 16'd100, 32'sd20000, 32'sd25000);
        push_sample(1'b0, 48'd600000, 1'b1, 16'd100, 32'sd20000, 32'sd25000);
        push_sample(1'b0, 48'hFFFF_FFFF_FFFF, 1'b1, 16'd100, 32'sd20000, 32'sd25000);
        push_sample(1'b1, 48'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
        wait_drained();

        // Random part: one register setting per phase, the idle pattern
        // cycling through none, sender only, receiver only and both.
        for (int k = 0; k < SETTING_COUNT; k++) begin
            case (k)
                0: c = '{min_draw_time_ms: 32'd20000, draw_level_dw: 16'd50,
                         hot_margin_mc: 16'd1000, gap_limit_ms: 32'd5000,
                         probe_min_mc: 32'sd0, probe_max_mc: 32'sd40000,
                         setpoint_min_mc: 32'sd18000, setpoint_max_mc: 32'sd32000};
                1: c = '0;
                2: c = '{min_draw_time_ms: 32'hFFFF_FFFF, draw_level_dw: 16'hFFFF,
                         hot_margin_mc: 16'hFFFF, gap_limit_ms: 32'hFFFF_FFFF,
                         probe_min_mc: 32'sh8000_0000, probe_max_mc: 32'sh7FFF_FFFF,
                         setpoint_min_mc: 32'sh8000_0000, setpoint_max_mc: 32'sh7FFF_FFFF};
                // Inverted bands reject every probe reading and setpoint.
                3: c = '{min_draw_time_ms: 32'd1000, draw_level_dw: 16'd10,
                         hot_margin_mc: 16'd100, gap_limit_ms: 32'd1000,
                         probe_min_mc: 32'sd40000, probe_max_mc: 32'sd0,
                         setpoint_min_mc: 32'sd32000, setpoint_max_mc: 32'sd18000};
                // The power-on sentinel lies inside this probe band.
                4: c = '{min_draw_time_ms: 32'd5000, draw_level_dw: 16'd100,
                         hot_margin_mc: 16'd500, gap_limit_ms: 32'd2000,
                         probe_min_mc: -32'sd1000, probe_max_mc: 32'sd90000,
                         setpoint_min_mc: 32'sd20000, setpoint_max_mc: 32'sd30000};
                // Full bands with the widest margin: setpoints near the top
                // make the over-target sum exceed the 32-bit range.
                5: c = '{min_draw_time_ms: 32'd0, draw_level_dw: 16'd0,
                         hot_margin_mc: 16'hFFFF, gap_limit_ms: 32'd100000,
                         probe_min_mc: 32'sh8000_0000, probe_max_mc: 32'sh7FFF_FFFF,
                         setpoint_min_mc: 32'sh8000_0000, setpoint_max_mc: 32'sh7FFF_FFFF};
                // Runs can outgrow 32 bits of elapsed time here.
                6: c = '{min_draw_time_ms: 32'hFFFF_FFFF, draw_level_dw: 16'd1,
                         hot_margin_mc: 16'd0, gap_limit_ms: 32'hFFFF_FFFF,
                         probe_min_mc: -32'sd200000, probe_max_mc: 32'sd200000,
                         setpoint_min_mc: -32'sd50000, setpoint_max_mc: 32'sd50000};
                default: c = '{min_draw_time_ms: RST_MIN_DRAW_TIME,
                               draw_level_dw: RST_DRAW_THRESHOLD,
                               hot_margin_mc: RST_OVER_TARGET, gap_limit_ms: RST_MAX_GAP,
                               probe_min_mc: RST_PROBE_MIN, probe_max_mc: RST_PROBE_MAX,
                               setpoint_min_mc: RST_SETPOINT_MIN,
                               setpoint_max_mc: RST_SETPOINT_MAX};
            endcase
            apb_write(REG_MIN_DRAW_TIME,  c.min_draw_time_ms);
            apb_write(REG_DRAW_THRESHOLD, {16'd0, c.draw_level_dw});
            apb_write(REG_OVER_TARGET,    {16'd0, c.hot_margin_mc});
            apb_write(REG_MAX_GAP,        c.gap_limit_ms);
            apb_write(REG_PROBE_MIN,      c.probe_min_mc);
            apb_write(REG_PROBE_MAX,      c.probe_max_mc);
            apb_write(REG_SETPOINT_MIN,   c.setpoint_min_mc);
            apb_write(REG_SETPOINT_MAX,   c.setpoint_max_mc);

            case (k % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 63;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 63;
                end
                default: begin
                    sender_idle_pct = 25;
                    recv_stall_pct  = 25;
                end
            endcase
            queue_random(WORDS_PER_SETTING);
            wait_drained();
            settings_done++;
        end

        repeat (10) @(negedge aclk);
        $display("Checked %0d verdict words (%0d sent) over %0d register settings",
                 words_checked, items_queued, settings_done + 1);
        $display("Verdicts matched: %0d unknown, %0d ok, %0d suspect, %0d fault; %0d failures",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
                 fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
